// ===== rtl/adam_wu_pkg.sv =====
// shared constants, codes and pipeline layout of the adam weight update table
package adam_wu_pkg;

  localparam int ENTRY_COUNT = 1024;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam int INDEX_W     = 10;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;

  // square root: one pipeline stage per two result bits
  localparam int ROOT_W      = 24;
  localparam int SQ_FIRST    = 4;
  localparam int SQ_STAGES   = ROOT_W / 2;
  localparam int DEN_STAGE   = SQ_FIRST + SQ_STAGES;
  // divider: one pipeline stage per two quotient bits
  localparam int QUO_W       = 32;
  localparam int DIV_FIRST   = DEN_STAGE + 1;
  localparam int DIV_STAGES  = QUO_W / 2;
  localparam int LAST_STAGE  = DIV_FIRST + DIV_STAGES;

  localparam logic [CFG_W-1:0] STEP_SIZE_RST    = 16'd66;
  localparam logic [CFG_W-1:0] FIRST_DECAY_RST  = 16'd58982;
  localparam logic [CFG_W-1:0] SECOND_DECAY_RST = 16'd65470;
  localparam logic [CFG_W-1:0] STABILIZER_RST   = 16'd1;

  // the spare code behaves as a read
  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_UPDATE   = 2'd1,
    ACT_READ     = 2'd2,
    ACT_READ_ALT = 2'd3
  } act_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP_SIZE    = 2'd0,
    CFG_FIRST_DECAY  = 2'd1,
    CFG_SECOND_DECAY = 2'd2,
    CFG_STABILIZER   = 2'd3
  } cfg_reg_e;

endpackage

// ===== rtl/adam_weight_update_top.sv =====
// adam weight update table: entry memory, pipelined moment update, square root and divider
// data path: an accepted beat passes through every pipeline stage and then the output
//   register, which drives m_axis_tdata
// throughput: one beat per cycle unless the pipeline freezes; a beat whose entry is still
//   being updated by a load or update in the pipeline waits until it has been written back
// the pipeline freezes only while its last stage is full and the output register is blocked
// reset clears valid bits, presets settings; table contents stay undefined until written
module adam_weight_update_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adam_wu_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [adam_wu_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // index [9:0], value [41:10], zero [47:42]
  input  logic [adam_wu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // entry_index [9:0], weight [41:10], first_moment [73:42], second_moment [105:74],
  // zero [111:106]
  output logic [adam_wu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import adam_wu_pkg::*;

  typedef struct packed {
    logic [1:0]        act;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       g;
    logic [31:0]       w;
    logic [31:0]       m;
    logic [31:0]       v;
    logic [31:0]       mn;
    logic [31:0]       vn;
    logic signed [49:0] pa;
    logic signed [49:0] pb;
    logic [63:0]       gg;
    logic [47:0]       va;
    logic [64:0]       vb;
    logic [47:0]       num;
    logic [ROOT_W-1:0] root;
    logic [25:0]       rem;
    logic [24:0]       den;
    logic [QUO_W-1:0]  q;
    logic              ovf;
  } stage_t;

  logic [CFG_W-1:0] step_size_q, first_decay_q, second_decay_q, stabilizer_q;

  logic [95:0] mem_q [ENTRY_COUNT];
  logic [95:0] rd_q;

  stage_t pipe_q [1:LAST_STAGE];
  stage_t pipe_d [1:LAST_STAGE];
  logic   vld_q  [1:LAST_STAGE];

  logic             out_vld_q;
  logic [95:0]      out_res_q;
  logic [IDX_W-1:0] out_idx_q;

  logic             adv, in_acc, hazard;
  logic [IDX_W-1:0] in_idx;
  logic [95:0]      res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q    <= STEP_SIZE_RST;
      first_decay_q  <= FIRST_DECAY_RST;
      second_decay_q <= SECOND_DECAY_RST;
      stabilizer_q   <= STABILIZER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_STEP_SIZE:    step_size_q    <= cfg_wdata_i;
        CFG_FIRST_DECAY:  first_decay_q  <= cfg_wdata_i;
        CFG_SECOND_DECAY: second_decay_q <= cfg_wdata_i;
        CFG_STABILIZER:   stabilizer_q   <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  assign in_idx = IDX_W'(s_axis_tdata[INDEX_W-1:0] % ENTRY_COUNT);

  // an entry with a pending write in the pipeline must not be read again yet
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= LAST_STAGE; k++) begin
      if (vld_q[k] && (pipe_q[k].act == ACT_LOAD || pipe_q[k].act == ACT_UPDATE) &&
          pipe_q[k].idx == in_idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign adv           = !(vld_q[LAST_STAGE] && out_vld_q && !m_axis_tready);
  assign s_axis_tready = adv && !hazard;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // stage logic
  always_comb begin
    stage_t             s;
    logic signed [16:0] b1s;
    logic [16:0]        c1, c2;
    logic [31:0]        ga, ma;
    logic signed [50:0] sm, sh;
    logic [65:0]        vs;
    logic [47:0]        x;
    logic [1:0]         pr;
    logic [27:0]        r2, tr;
    logic [24:0]        dsum;
    logic [25:0]        d2;

    s           = '0;
    s.act       = s_axis_tuser;
    s.idx       = in_idx;
    s.g         = s_axis_tdata[INDEX_W +: DATA_W];
    pipe_d[1]   = s;

    for (int k = 1; k < LAST_STAGE; k++) begin
      s = pipe_q[k];
      if (k == 1) begin
        s.w  = rd_q[95:64];
        s.m  = rd_q[63:32];
        s.v  = rd_q[31:0];
        b1s  = $signed({1'b0, first_decay_q});
        c1   = 17'h10000 - {1'b0, first_decay_q};
        s.pa = b1s * $signed(s.m);
        s.pb = $signed({1'b0, c1}) * $signed(s.g);
        ga   = s.g[31] ? 32'(-s.g) : s.g;
        s.gg = {32'b0, ga} * {32'b0, ga};
      end else if (k == 2) begin
        sm   = 51'(s.pa) + 51'(s.pb);
        sh   = sm >>> 16;
        s.mn = (sh[50:31] == {20{sh[31]}}) ? sh[31:0] :
               (sh[50] ? 32'h8000_0000 : 32'h7fff_ffff);
        c2   = 17'h10000 - {1'b0, second_decay_q};
        s.va = {32'b0, second_decay_q} * {16'b0, s.v};
        s.vb = {48'b0, c2} * {17'b0, s.gg[63:16]};
      end else if (k == 3) begin
        vs     = 66'(s.va) + 66'(s.vb);
        s.vn   = (|vs[65:48]) ? 32'hffff_ffff : vs[47:16];
        ma     = s.mn[31] ? 32'(-s.mn) : s.mn;
        s.num  = {32'b0, step_size_q} * {16'b0, ma};
        s.root = '0;
        s.rem  = '0;
      end else if (k < DEN_STAGE) begin
        // two result bits of the integer square root per stage
        x = {s.vn, 16'b0};
        for (int h = 0; h < 2; h++) begin
          pr = x[47 - 2 * (2 * (k - SQ_FIRST) + h) -: 2];
          r2 = {s.rem, pr};
          tr = {2'b0, s.root, 2'b01};
          if (r2 >= tr) begin
            s.rem  = 26'(r2 - tr);
            s.root = {s.root[ROOT_W-2:0], 1'b1};
          end else begin
            s.rem  = 26'(r2);
            s.root = {s.root[ROOT_W-2:0], 1'b0};
          end
        end
      end else if (k == DEN_STAGE) begin
        dsum  = {1'b0, s.root} + 25'(stabilizer_q);
        s.den = (dsum == '0) ? 25'd1 : dsum;
      end else begin
        // quotient of 32 bits; a larger one is flagged up front
        if (k == DIV_FIRST) begin
          s.ovf = 25'(s.num[47:32]) >= s.den;
          s.rem = 26'(s.num[47:32]);
        end
        for (int h = 0; h < 2; h++) begin
          d2 = {s.rem[24:0], s.num[QUO_W - 1 - (2 * (k - DIV_FIRST) + h)]};
          if (d2 >= {1'b0, s.den}) begin
            s.rem = d2 - {1'b0, s.den};
            s.q   = {s.q[QUO_W-2:0], 1'b1};
          end else begin
            s.rem = d2;
            s.q   = {s.q[QUO_W-2:0], 1'b0};
          end
        end
      end
      pipe_d[k+1] = s;
    end
  end

  // weight step and result selection
  always_comb begin
    stage_t             f;
    logic [31:0]        qs, wn;
    logic signed [33:0] stp, wd;

    f   = pipe_q[LAST_STAGE];
    qs  = (f.ovf || f.q > 32'h8000_0000) ? 32'h8000_0000 : f.q;
    stp = f.mn[31] ? -$signed({2'b0, qs}) : $signed({2'b0, qs});
    wd  = $signed({{2{f.w[31]}}, f.w}) - stp;
    wn  = (wd[33:31] == {3{wd[31]}}) ? wd[31:0] :
          (wd[33] ? 32'h8000_0000 : 32'h7fff_ffff);
    case (f.act)
      ACT_LOAD:   res = {f.g, 32'b0, 32'b0};
      ACT_UPDATE: res = {wn, f.mn, f.vn};
      default:    res = {f.w, f.m, f.v};
    endcase
  end

  // table memory: read at acceptance, write back from the last stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[in_idx];
    end
    if (adv && vld_q[LAST_STAGE]) begin
      mem_q[pipe_q[LAST_STAGE].idx] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 1; k <= LAST_STAGE; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
    if (adv && vld_q[LAST_STAGE]) begin
      out_res_q <= res;
      out_idx_q <= pipe_q[LAST_STAGE].idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAST_STAGE; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q[1] <= in_acc;
        for (int k = 2; k <= LAST_STAGE; k++) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (adv && vld_q[LAST_STAGE]) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_res_q[31:0], out_res_q[63:32], out_res_q[95:64],
                          INDEX_W'(out_idx_q)};

endmodule

// ===== rtl/adam_wu_checker.sv =====
// port-level checks on the adam weight update table, bound to its top level
module adam_wu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [adam_wu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import adam_wu_pkg::*;

  logic [7:0] open_q;

  // beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 8'(s_axis_tvalid && s_axis_tready) -
                8'(m_axis_tvalid && m_axis_tready);
    end
  end

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != '0)
    else $error("output beat with no accepted input behind it");

  a_bounded_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 8'(LAST_STAGE + 1))
    else $error("more beats in flight than pipeline and output register hold");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind adam_weight_update_top adam_wu_checker u_adam_wu_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench for the adam weight update table
module tb;
  import adam_wu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 50;

  // laid out as on the output bus, entry index in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0]  v;
    logic [DATA_W-1:0]  m;
    logic [DATA_W-1:0]  w;
    logic [INDEX_W-1:0] idx;
  } entry_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  adam_weight_update_top u_top (.*);

  always #10 clk_i = ~clk_i;

  // local copy of the table and its settings
  logic [DATA_W-1:0] weight_copy [ENTRY_COUNT];
  logic [DATA_W-1:0] first_copy  [ENTRY_COUNT];
  logic [DATA_W-1:0] second_copy [ENTRY_COUNT];
  bit                loaded      [ENTRY_COUNT];
  int                loaded_list [$];
  logic [CFG_W-1:0]  lr_q  = STEP_SIZE_RST;
  logic [CFG_W-1:0]  b1_q  = FIRST_DECAY_RST;
  logic [CFG_W-1:0]  b2_q  = SECOND_DECAY_RST;
  logic [CFG_W-1:0]  eps_q = STABILIZER_RST;

  entry_t pending_entries [$];
  int     errors = 0;
  bit     calm = 1'b0;
  int     quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // applies one item to the local table and returns the entry afterwards
  function automatic entry_t adam_entry_after(logic [1:0] act, int i, logic [DATA_W-1:0] value);
    entry_t e;
    longint w, m, g, b1, step;
    longint unsigned v, b2, mag_g, g2, vs, den, mag_m, q;
    if (act == ACT_LOAD) begin
      weight_copy[i] = value;
      first_copy[i]  = '0;
      second_copy[i] = '0;
      if (!loaded[i]) loaded_list.push_back(i);
      loaded[i] = 1'b1;
    end else if (act == ACT_UPDATE) begin
      w  = $signed(weight_copy[i]);
      m  = $signed(first_copy[i]);
      v  = second_copy[i];
      g  = $signed(value);
      b1 = longint'(b1_q);
      b2 = 64'(b2_q);
      mag_g = (g < 0) ? -g : g;
      g2 = (mag_g * mag_g) >> 16;
      m  = sat32((b1 * m + (65536 - b1) * g) >>> 16);
      vs = (b2 * v + (65536 - b2) * g2) >> 16;
      if (vs > 64'hFFFF_FFFF) vs = 64'hFFFF_FFFF;
      den = int_sqrt(vs << 16) + eps_q;
      if (den == 0) den = 1;
      mag_m = (m < 0) ? -m : m;
      q = (lr_q * mag_m) / den;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      step = (m < 0) ? -longint'(q) : longint'(q);
      w = sat32(w - step);
      weight_copy[i] = w[31:0];
      first_copy[i]  = m[31:0];
      second_copy[i] = vs[31:0];
    end
    e.idx = i[INDEX_W-1:0];
    e.w   = weight_copy[i];
    e.m   = first_copy[i];
    e.v   = second_copy[i];
    return e;
  endfunction

  task automatic send_beat(logic [1:0] act, int i, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'b0, value, i[INDEX_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_entries.push_back(adam_entry_after(act, i, value));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_entries.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] d);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      CFG_STEP_SIZE:    lr_q  = d;
      CFG_FIRST_DECAY:  b1_q  = d;
      CFG_SECOND_DECAY: b2_q  = d;
      default:          eps_q = d;
    endcase
  endtask

  task automatic write_all(logic [CFG_W-1:0] lr, logic [CFG_W-1:0] b1,
                           logic [CFG_W-1:0] b2, logic [CFG_W-1:0] eps);
    write_reg(CFG_STEP_SIZE, lr);
    write_reg(CFG_FIRST_DECAY, b1);
    write_reg(CFG_SECOND_DECAY, b2);
    write_reg(CFG_STABILIZER, eps);
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(0, 1 << 24) - (1 << 23);
      3: return $urandom_range(0, 1 << 18) - (1 << 17);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_load_read();
    send_beat(ACT_LOAD, 0, 32'h7FFF_FFFF);
    send_beat(ACT_LOAD, ENTRY_COUNT - 1, 32'h8000_0000);
    send_beat(ACT_LOAD, 5, 32'h0);
    send_beat(ACT_READ, 0, 32'hFFFF_FFFF);
    send_beat(ACT_READ, ENTRY_COUNT - 1, 32'h0);
    // the spare action reads the entry
    send_beat(ACT_READ_ALT, 5, 32'h1234_5678);
  endtask

  task automatic test_update_extremes();
    send_beat(ACT_UPDATE, 0, 32'h7FFF_FFFF);
    send_beat(ACT_UPDATE, 0, 32'h8000_0000);
    send_beat(ACT_UPDATE, ENTRY_COUNT - 1, 32'h8000_0000);
    send_beat(ACT_UPDATE, 5, 32'h0);
    send_beat(ACT_UPDATE, 5, 32'h0001_0000);
    send_beat(ACT_READ, 5, 32'h0);
  endtask

  task automatic test_config_extremes();
    // zero stabiliser with zero root forces the divisor to one
    write_all(16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_beat(ACT_LOAD, 7, 32'h8000_0000);
    send_beat(ACT_UPDATE, 7, 32'h0);
    send_beat(ACT_UPDATE, 7, 32'h0000_0001);
    send_beat(ACT_UPDATE, 7, 32'h7FFF_FFFF);
    send_beat(ACT_UPDATE, ENTRY_COUNT - 1, 32'h8000_0000);
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_UPDATE, 7, 32'h8000_0000);
    send_beat(ACT_UPDATE, 0, 32'h7FFF_FFFF);
    send_beat(ACT_READ, 7, 32'h0);
  endtask

  task automatic test_random_phase(int items, bit quiet);
    int r, i;
    logic [1:0] act;
    calm = quiet;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2 && $urandom_range(0, 1)) begin
        stop_sending();
        while (pending_entries.size() != 0) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 20 || loaded_list.size() == 0) begin
        act = ACT_LOAD;
        i = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, ENTRY_COUNT - 1);
      end else begin
        act = (r < 80) ? ACT_UPDATE :
              ($urandom_range(0, 19) == 0 ? ACT_READ_ALT : ACT_READ);
        // a few entries often, so that back-to-back hits on one entry occur
        if ($urandom_range(0, 1))
          i = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        else
          i = loaded_list[$urandom_range(0, loaded_list.size() < 4 ? loaded_list.size() - 1 : 3)];
      end
      send_beat(act, i, rand_value());
    end
    calm = 1'b0;
  endtask

  task automatic test_random();
    test_random_phase(250, 1'b0);
    write_all(STEP_SIZE_RST, FIRST_DECAY_RST, SECOND_DECAY_RST, STABILIZER_RST);
    test_random_phase(250, 1'b1);
    for (int p = 0; p < 4; p++) begin
      write_all(CFG_W'($urandom_range(0, 16'hFFFF)), CFG_W'($urandom_range(0, 16'hFFFF)),
                CFG_W'($urandom_range(0, 16'hFFFF)), CFG_W'($urandom_range(1, 16'hFFFF)));
      test_random_phase(260, 1'b0);
    end
  endtask

  // result checker
  always @(negedge clk_i)
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);

  always @(posedge clk_i) begin
    entry_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[105:0];
      if (pending_entries.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        if (got.idx !== want.idx) begin
          $error("entry_index expected %0d got %0d", want.idx, got.idx); errors++;
        end
        if (got.w !== want.w) begin
          $error("weight expected %h got %h", want.w, got.w); errors++;
        end
        if (got.m !== want.m) begin
          $error("first_moment expected %h got %h", want.m, got.m); errors++;
        end
        if (got.v !== want.v) begin
          $error("second_moment expected %h got %h", want.v, got.v); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_load_read();
    test_update_extremes();
    test_config_extremes();
    test_random();
    wait_drained();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
